### rtl/ttam_pkg.sv
// shared constants and codes for the tensor transpose address map
// no dependencies
package ttam_pkg;

    // quotient bits resolved per divider stage
    localparam int DIV_STEP_BITS = 4;

    typedef enum logic [1:0] {
        REG_RANK        = 2'd0,
        REG_SOURCE_DIMS = 2'd1,
        REG_AXIS_ORDER  = 2'd2,
        REG_REVERSE_ALL = 2'd3
    } cfg_reg_t;

endpackage

### rtl/ttam_div_stage.sv
// pipelined restoring divider for one destination axis, with side payload
// depends on ttam_pkg
module ttam_div_stage
    import ttam_pkg::*;
#(
    parameter int IW = 32,
    parameter int DW = 16,
    parameter int PW = 96
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [IW-1:0] in_rem,
    input  logic [PW-1:0] in_pay,
    input  logic [DW-1:0] divisor,
    input  logic          bypass,
    output logic          out_valid,
    output logic [IW-1:0] out_rem,
    output logic [DW-1:0] out_mod,
    output logic [PW-1:0] out_pay
);

    localparam int NS = (IW + DIV_STEP_BITS - 1) / DIV_STEP_BITS;

    logic          v_in    [NS];
    logic [DW-1:0] part_in [NS];
    logic [IW-1:0] sh_in   [NS];
    logic [IW-1:0] orig_in [NS];
    logic [PW-1:0] pay_in  [NS];

    logic          v_reg    [NS];
    logic [DW-1:0] part_reg [NS];
    logic [IW-1:0] sh_reg   [NS];
    logic [IW-1:0] orig_reg [NS];
    logic [PW-1:0] pay_reg  [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            logic [DW-1:0] part_next;
            logic [IW-1:0] sh_next;

            if (s == 0) begin : g_first
                assign v_in[s]    = in_valid;
                assign part_in[s] = '0;
                assign sh_in[s]   = in_rem;
                assign orig_in[s] = in_rem;
                assign pay_in[s]  = in_pay;
            end else begin : g_rest
                assign v_in[s]    = v_reg[s-1];
                assign part_in[s] = part_reg[s-1];
                assign sh_in[s]   = sh_reg[s-1];
                assign orig_in[s] = orig_reg[s-1];
                assign pay_in[s]  = pay_reg[s-1];
            end

            // shift one dividend bit in, subtract when it fits
            always_comb
            begin
                logic [DW:0] t;
                part_next = part_in[s];
                sh_next   = sh_in[s];
                t         = '0;
                for (int b = 0; b < DIV_STEP_BITS; b++)
                begin
                    if (s * DIV_STEP_BITS + b < IW)
                    begin
                        t       = {part_next, sh_next[IW-1]};
                        sh_next = {sh_next[IW-2:0], 1'b0};
                        if (t >= {1'b0, divisor})
                        begin
                            t          = t - {1'b0, divisor};
                            sh_next[0] = 1'b1;
                        end
                        part_next = t[DW-1:0];
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else
                begin
                    v_reg[s] <= v_in[s];
                end
            end

            always_ff @(posedge clk)
            begin
                part_reg[s] <= part_next;
                sh_reg[s]   <= sh_next;
                orig_reg[s] <= orig_in[s];
                pay_reg[s]  <= pay_in[s];
            end
        end
    endgenerate

    // skipped axis or zero size: coordinate 0, index passed on
    assign out_valid = v_reg[NS-1];
    assign out_rem   = bypass ? orig_reg[NS-1] : sh_reg[NS-1];
    assign out_mod   = bypass ? '0 : part_reg[NS-1];
    assign out_pay   = pay_reg[NS-1];

endmodule

### rtl/tensor_transpose_address_map_unit.sv
// transposed tensor address map: destination linear index to source index
// pipelined through the per-axis dividers, a scatter register, the recombine stages and
// an output register; one item accepted every cycle
// busy is always low and the receiver cannot stall; done pulses one cycle per item
// reset clears all valid bits and loads the register defaults; depends on ttam_pkg
module tensor_transpose_address_map_unit
    import ttam_pkg::*;
#(
    parameter int MAX_RANK   = 4,
    parameter int DIM_BITS   = 16,
    parameter int INDEX_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] dest_index,
    output logic        done,
    output logic [31:0] source_index,
    output logic [31:0] dest_index_echo,
    output logic        out_of_range
);

    // working index width: results are masked to 32 bits anyway
    localparam int IW   = (INDEX_BITS < 32) ? INDEX_BITS : 32;
    localparam int DW   = DIM_BITS;
    localparam int NDIM = (MAX_RANK > 4) ? MAX_RANK : 4;
    localparam int AXW  = $clog2(NDIM);
    localparam int RW   = $clog2(MAX_RANK + 1);
    localparam int KW   = (AXW > RW) ? AXW : RW;
    localparam int CW   = IW + 1;
    localparam int PW   = IW + MAX_RANK * DW;

    // ---------------- configuration registers ----------------
    logic [2:0]  rank_reg;
    logic [63:0] source_dims_reg;
    logic [7:0]  axis_order_reg;
    logic        reverse_all_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg        <= 3'd4;
            source_dims_reg <= '0;
            axis_order_reg  <= 8'd228;
            reverse_all_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RANK:        rank_reg        <= cfg_wdata[2:0];
                REG_SOURCE_DIMS: source_dims_reg <= cfg_wdata;
                REG_AXIS_ORDER:  axis_order_reg  <= cfg_wdata[7:0];
                REG_REVERSE_ALL: reverse_all_reg <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // ---------------- decoded configuration ----------------
    // dimension sizes, bits past the register read as zero
    logic [63+DW:0] dims_ext;
    logic [DW-1:0]  dims [2**AXW];

    assign dims_ext = {{DW{1'b0}}, source_dims_reg};

    genvar g;
    generate
        for (g = 0; g < 2**AXW; g++) begin : g_dim
            localparam int POS = g * DW;
            if (POS >= 64) begin : g_zero
                assign dims[g] = '0;
            end else begin : g_take
                assign dims[g] = dims_ext[POS +: DW];
            end
        end
    endgenerate

    // effective rank clamped into 1..MAX_RANK
    logic [RW-1:0] reff;

    always_comb
    begin
        if (rank_reg == 3'd0)
            reff = RW'(1);
        else if (32'(rank_reg) > 32'(MAX_RANK))
            reff = RW'(MAX_RANK);
        else
            reff = RW'(rank_reg);
    end

    // source axis for each destination axis
    logic [AXW-1:0] ax      [MAX_RANK];
    logic           ax_live [MAX_RANK];

    generate
        for (g = 0; g < MAX_RANK; g++) begin : g_ax
            logic [AXW-1:0] ax_cfg;
            if (g < 4) begin : g_field
                assign ax_cfg = AXW'(axis_order_reg[2*g +: 2]);
            end else begin : g_none
                assign ax_cfg = '0;
            end
            assign ax[g] = reverse_all_reg ? AXW'(reff - RW'(1) - RW'(g)) : ax_cfg;
            // coordinate kept only when the named source axis is in use
            assign ax_live[g] = (KW'(g) < KW'(reff)) && (KW'(ax[g]) < KW'(reff));
        end
    endgenerate

    // ---------------- element count, free running ----------------
    // capped at 2^IW, which already exceeds every index
    logic [CW-1:0] cnt_reg [MAX_RANK];

    generate
        for (g = 0; g < MAX_RANK; g++) begin : g_cnt
            logic [CW-1:0]    c_prev;
            logic [DW-1:0]    c_mul;
            logic [CW+DW-1:0] c_prod;
            logic [CW-1:0]    cnt_next;

            if (g == 0) begin : g_first
                assign c_prev = CW'(1);
            end else begin : g_rest
                assign c_prev = cnt_reg[g-1];
            end

            assign c_mul  = (KW'(g) < KW'(reff)) ? dims[g] : DW'(1);
            assign c_prod = (CW+DW)'(c_prev) * (CW+DW)'(c_mul);

            always_comb
            begin
                if (c_prod > ((CW+DW)'(1) << IW))
                    cnt_next = CW'(1) << IW;
                else
                    cnt_next = c_prod[CW-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    cnt_reg[g] <= '0;
                else
                    cnt_reg[g] <= cnt_next;
            end
        end
    endgenerate

    // ---------------- split over destination shape ----------------
    // chain runs from the last destination axis down to axis zero
    logic          dv_v   [MAX_RANK+1];
    logic [IW-1:0] dv_rem [MAX_RANK+1];
    logic [PW-1:0] dv_pay [MAX_RANK+1];

    assign busy = 1'b0;

    assign dv_v[MAX_RANK]   = start;
    assign dv_rem[MAX_RANK] = dest_index[IW-1:0];
    assign dv_pay[MAX_RANK] = {dest_index[IW-1:0], {(MAX_RANK*DW){1'b0}}};

    generate
        for (g = 0; g < MAX_RANK; g++) begin : g_split
            logic [DW-1:0] d_size;
            logic          d_skip;
            logic [DW-1:0] d_mod;
            logic [PW-1:0] d_pay;

            assign d_size = dims[ax[g]];
            assign d_skip = (KW'(g) >= KW'(reff)) || (d_size == '0);

            ttam_div_stage #(
                .IW (IW),
                .DW (DW),
                .PW (PW)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (dv_v[g+1]),
                .in_rem    (dv_rem[g+1]),
                .in_pay    (dv_pay[g+1]),
                .divisor   (d_size),
                .bypass    (d_skip),
                .out_valid (dv_v[g]),
                .out_rem   (dv_rem[g]),
                .out_mod   (d_mod),
                .out_pay   (d_pay)
            );

            // drop this axis's coordinate into its slot
            always_comb
            begin
                dv_pay[g]             = d_pay;
                dv_pay[g][g*DW +: DW] = d_mod;
            end
        end
    endgenerate

    // ---------------- scatter to source axes ----------------
    logic          sc_v_reg;
    logic [IW-1:0] sc_di_reg;
    logic [DW-1:0] sc_reg  [MAX_RANK];
    logic [DW-1:0] sc_next [MAX_RANK];

    // later destination axis wins on repeats
    always_comb
    begin
        for (int k = 0; k < MAX_RANK; k++)
        begin
            sc_next[k] = '0;
            for (int i = 0; i < MAX_RANK; i++)
            begin
                if (ax_live[i] && (KW'(ax[i]) == KW'(k)))
                    sc_next[k] = dv_pay[0][i*DW +: DW];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_v_reg <= 1'b0;
        else
            sc_v_reg <= dv_v[0];
    end

    always_ff @(posedge clk)
    begin
        sc_di_reg <= dv_pay[0][PW-1 -: IW];
        for (int k = 0; k < MAX_RANK; k++)
            sc_reg[k] <= sc_next[k];
    end

    // ---------------- recombine over source shape ----------------
    // one multiply-add per stage, wraps modulo 2^IW
    logic          rc_v_reg  [MAX_RANK];
    logic [IW-1:0] rc_si_reg [MAX_RANK];
    logic [IW-1:0] rc_di_reg [MAX_RANK];
    logic [DW-1:0] rc_sc_reg [MAX_RANK][MAX_RANK];

    generate
        for (g = 0; g < MAX_RANK; g++) begin : g_comb
            logic          r_v;
            logic [IW-1:0] r_si;
            logic [IW-1:0] r_di;
            logic [DW-1:0] r_sc [MAX_RANK];
            logic [IW+DW-1:0] r_sum;
            logic [IW-1:0] si_next;

            if (g == 0) begin : g_first
                assign r_v  = sc_v_reg;
                assign r_si = '0;
                assign r_di = sc_di_reg;
                assign r_sc = sc_reg;
            end else begin : g_rest
                assign r_v  = rc_v_reg[g-1];
                assign r_si = rc_si_reg[g-1];
                assign r_di = rc_di_reg[g-1];
                assign r_sc = rc_sc_reg[g-1];
            end

            assign r_sum = (IW+DW)'(r_si) * (IW+DW)'(dims[g]) + (IW+DW)'(r_sc[g]);
            assign si_next = (KW'(g) < KW'(reff)) ? r_sum[IW-1:0] : r_si;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    rc_v_reg[g] <= 1'b0;
                else
                    rc_v_reg[g] <= r_v;
            end

            always_ff @(posedge clk)
            begin
                rc_si_reg[g] <= si_next;
                rc_di_reg[g] <= r_di;
                rc_sc_reg[g] <= r_sc;
            end
        end
    endgenerate

    // ---------------- range check and output register ----------------
    logic          done_reg;
    logic [IW-1:0] src_reg;
    logic [IW-1:0] echo_reg;
    logic          oor_reg;
    logic          oor_next;

    assign oor_next = CW'(rc_di_reg[MAX_RANK-1]) >= cnt_reg[MAX_RANK-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= rc_v_reg[MAX_RANK-1];
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= oor_next ? '0 : rc_si_reg[MAX_RANK-1];
        echo_reg <= rc_di_reg[MAX_RANK-1];
        oor_reg  <= oor_next;
    end

    assign done            = done_reg;
    assign source_index    = 32'(src_reg);
    assign dest_index_echo = 32'(echo_reg);
    assign out_of_range    = oor_reg;

endmodule
